// ===== hdl/lkat_pkg.sv =====
// ----------------------------------------------------------------------------
// lkat_pkg
// Shared types and fixed-point constants for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package lkat_pkg;

    typedef logic signed [31:0] q32_t;
    typedef logic signed [63:0] w64_t;
    typedef logic signed [33:0] rnd_t;

    // normalizer widths
    localparam int MAG_W    = 63;               // component magnitude
    localparam int NRM_W    = 31;               // magnitude after common shift
    localparam int SQ_W     = 2 * NRM_W;        // one square
    localparam int SUM_W    = 64;               // sum of three squares
    localparam int ROOT_W   = SUM_W / 2;        // vector length
    localparam int NUM_W    = SQ_W;             // divider numerator
    localparam int FRAC_W   = 30;               // Q2.30 fraction bits
    localparam int SHF_STG  = 3;                // shift stages, two steps each
    localparam int SQRT_STG = ROOT_W / 2;       // two root bits per stage
    localparam int DIV_STG  = (NRM_W + 1) / 2;  // two quotient bits per stage, one in the last

    localparam q32_t ONE_Q30 = 32'sh4000_0000;
    localparam w64_t RND_POS = 64'sd536870912;
    localparam w64_t RND_NEG = 64'sd536870911;
    localparam q32_t SAT_MAX = 32'sh7fff_ffff;
    localparam q32_t SAT_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

// ===== hdl/lkat_norm.sv =====
// ----------------------------------------------------------------------------
// lkat_norm
// Pipelined vector normalizer: common shift, length by square root, and
// three rounded divisions to a Q2.30 unit vector. Carries a sideband along.
// ----------------------------------------------------------------------------
`default_nettype none

module lkat_norm
    import lkat_pkg::*;
#(
    parameter int SIDE_W = 192
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  w64_t              in_vec [3],
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output q32_t              out_vec [3],
    output logic [SIDE_W-1:0] out_side
);

    typedef logic [MAG_W-1:0]  mag_t;
    typedef logic [NRM_W-1:0]  nrm_t;
    typedef logic [ROOT_W-1:0] len_t;

    typedef struct {
        logic              valid;
        logic              neg [3];
        mag_t              mag [3];
        mag_t              orw;
        logic [SIDE_W-1:0] side;
    } shf_t;

    typedef struct {
        logic              valid;
        logic              neg [3];
        logic              zero;
        nrm_t              nm [3];
        logic [SQ_W-1:0]   sq [3];
        logic [SIDE_W-1:0] side;
    } sqr_t;

    typedef struct {
        logic              valid;
        logic              neg [3];
        logic              zero;
        nrm_t              nm [3];
        logic [SUM_W-1:0]  rad;
        logic [ROOT_W:0]   rem;
        len_t              root;
        logic [SIDE_W-1:0] side;
    } sqt_t;

    typedef struct {
        logic              valid;
        logic              neg [3];
        logic              zero;
        len_t              len;
        len_t              rem [3];
        nrm_t              nb [3];
        nrm_t              q [3];
        logic [SIDE_W-1:0] side;
    } div_t;

    function automatic shf_t shf_step(shf_t x, int amt);
        shf_t y;
        y = x;
        if ((x.orw >> (MAG_W - amt)) == '0) begin
            y.orw = x.orw << amt;
            for (int i = 0; i < 3; i++) begin
                y.mag[i] = x.mag[i] << amt;
            end
        end
        return y;
    endfunction

    function automatic sqt_t sqt_step(sqt_t x);
        sqt_t            y;
        logic [ROOT_W+2:0] acc;
        logic [ROOT_W+2:0] trial;
        y     = x;
        acc   = {x.rem, x.rad[SUM_W-1 -: 2]};
        trial = {1'b0, x.root, 2'b01};
        y.rad = x.rad << 2;
        if (acc >= trial) begin
            y.rem  = (ROOT_W+1)'(acc - trial);
            y.root = {x.root[ROOT_W-2:0], 1'b1};
        end else begin
            y.rem  = acc[ROOT_W:0];
            y.root = {x.root[ROOT_W-2:0], 1'b0};
        end
        return y;
    endfunction

    function automatic div_t div_step(div_t x);
        div_t          y;
        logic [ROOT_W:0] acc;
        y = x;
        for (int i = 0; i < 3; i++) begin
            acc     = {x.rem[i], x.nb[i][NRM_W-1]};
            y.nb[i] = x.nb[i] << 1;
            if (acc >= {1'b0, x.len}) begin
                y.rem[i] = ROOT_W'(acc - {1'b0, x.len});
                y.q[i]   = {x.q[i][NRM_W-2:0], 1'b1};
            end else begin
                y.rem[i] = acc[ROOT_W-1:0];
                y.q[i]   = {x.q[i][NRM_W-2:0], 1'b0};
            end
        end
        return y;
    endfunction

    shf_t shf_in;
    shf_t shf_reg  [0:SHF_STG];
    shf_t shf_next [1:SHF_STG];
    sqr_t sqr_next, sqr_reg;
    sqt_t sqt_in;
    sqt_t sqt_reg  [0:SQRT_STG];
    sqt_t sqt_next [1:SQRT_STG];
    div_t div_in;
    div_t div_reg  [0:DIV_STG];
    div_t div_next [1:DIV_STG];

    logic              out_valid_reg;
    q32_t              out_vec_reg [3];
    logic [SIDE_W-1:0] out_side_reg;
    q32_t              out_vec_next [3];

    // sign and magnitude
    always_comb begin
        w64_t abs_v;
        shf_in.valid = in_valid;
        shf_in.side  = in_side;
        shf_in.orw   = '0;
        for (int i = 0; i < 3; i++) begin
            abs_v          = in_vec[i][63] ? -in_vec[i] : in_vec[i];
            shf_in.neg[i]  = in_vec[i][63];
            shf_in.mag[i]  = abs_v[MAG_W-1:0];
            shf_in.orw     = shf_in.orw | abs_v[MAG_W-1:0];
        end
    end

    // common left shift: top set bit of the OR goes to the word's MSB
    for (genvar g = 1; g <= SHF_STG; g++) begin : g_shf
        always_comb begin
            shf_next[g] = shf_step(shf_step(shf_reg[g-1], (MAG_W + 1) >> (2*g - 1)),
                                   (MAG_W + 1) >> (2*g));
        end
    end

    always_comb begin
        sqr_next.valid = shf_reg[SHF_STG].valid;
        sqr_next.neg   = shf_reg[SHF_STG].neg;
        sqr_next.side  = shf_reg[SHF_STG].side;
        sqr_next.zero  = (shf_reg[SHF_STG].orw == '0);
        for (int i = 0; i < 3; i++) begin
            sqr_next.nm[i] = shf_reg[SHF_STG].mag[i][MAG_W-1 -: NRM_W];
            sqr_next.sq[i] = SQ_W'(sqr_next.nm[i]) * SQ_W'(sqr_next.nm[i]);
        end
    end

    always_comb begin
        sqt_in.valid = sqr_reg.valid;
        sqt_in.neg   = sqr_reg.neg;
        sqt_in.zero  = sqr_reg.zero;
        sqt_in.nm    = sqr_reg.nm;
        sqt_in.side  = sqr_reg.side;
        sqt_in.rad   = SUM_W'(sqr_reg.sq[0]) + SUM_W'(sqr_reg.sq[1]) + SUM_W'(sqr_reg.sq[2]);
        sqt_in.rem   = '0;
        sqt_in.root  = '0;
    end

    for (genvar g = 1; g <= SQRT_STG; g++) begin : g_sqt
        always_comb begin
            sqt_next[g] = sqt_step(sqt_step(sqt_reg[g-1]));
        end
    end

    // numerator = mag * 2^30 + len / 2; top bits seed the remainder
    always_comb begin
        logic [NUM_W-1:0] num;
        div_in.valid = sqt_reg[SQRT_STG].valid;
        div_in.neg   = sqt_reg[SQRT_STG].neg;
        div_in.zero  = sqt_reg[SQRT_STG].zero;
        div_in.side  = sqt_reg[SQRT_STG].side;
        div_in.len   = sqt_reg[SQRT_STG].root;
        for (int i = 0; i < 3; i++) begin
            num = (NUM_W'(sqt_reg[SQRT_STG].nm[i]) << FRAC_W)
                + NUM_W'(sqt_reg[SQRT_STG].root >> 1);
            div_in.rem[i] = ROOT_W'(num[NUM_W-1:NRM_W]);
            div_in.nb[i]  = num[NRM_W-1:0];
            div_in.q[i]   = '0;
        end
    end

    for (genvar g = 1; g <= DIV_STG; g++) begin : g_div
        if (2*g <= NRM_W) begin : g_two
            always_comb div_next[g] = div_step(div_step(div_reg[g-1]));
        end else begin : g_one
            always_comb div_next[g] = div_step(div_reg[g-1]);
        end
    end

    always_comb begin
        q32_t qv;
        for (int i = 0; i < 3; i++) begin
            qv = q32_t'({1'b0, div_reg[DIV_STG].q[i]});
            if (div_reg[DIV_STG].zero) begin
                out_vec_next[i] = '0;
            end else begin
                out_vec_next[i] = div_reg[DIV_STG].neg[i] ? -qv : qv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int g = 0; g <= SHF_STG; g++) begin
                shf_reg[g].valid <= 1'b0;
            end
            sqr_reg.valid <= 1'b0;
            for (int g = 0; g <= SQRT_STG; g++) begin
                sqt_reg[g].valid <= 1'b0;
            end
            for (int g = 0; g <= DIV_STG; g++) begin
                div_reg[g].valid <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            shf_reg[0] <= shf_in;
            for (int g = 1; g <= SHF_STG; g++) begin
                shf_reg[g] <= shf_next[g];
            end
            sqr_reg    <= sqr_next;
            sqt_reg[0] <= sqt_in;
            for (int g = 1; g <= SQRT_STG; g++) begin
                sqt_reg[g] <= sqt_next[g];
            end
            div_reg[0] <= div_in;
            for (int g = 1; g <= DIV_STG; g++) begin
                div_reg[g] <= div_next[g];
            end
            out_valid_reg <= div_reg[DIV_STG].valid;
            out_vec_reg   <= out_vec_next;
            out_side_reg  <= div_reg[DIV_STG].side;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_vec   = out_vec_reg;
    assign out_side  = out_side_reg;

endmodule

`default_nettype wire

// ===== hdl/look_at_view_matrix.sv =====
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Camera view matrix from eye, target and up hint: rows side, true up and
// back in Q2.30, translation column in saturated Q16.16.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  s_       in   s_valid/s_ready    eye, target, hint_up (9 x Q16.16)
//  m_       out  m_valid/m_ready    side, true_up, back (Q2.30), shift (Q16.16)
//
//  One transaction accepted per cycle unless the output stalls. Each normalizer
//  has a 16-stage square root and divider, two bits a stage (one in divider's last).
//  aresetn is synchronous; it clears the valid bits only.
//  While m_valid is high and m_ready low the whole pipeline holds and
//  s_ready is low; nothing is dropped or duplicated.
// ----------------------------------------------------------------------------
`default_nettype none

module look_at_view_matrix
    import lkat_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  q32_t s_eye_x,
    input  q32_t s_eye_y,
    input  q32_t s_eye_z,
    input  q32_t s_target_x,
    input  q32_t s_target_y,
    input  q32_t s_target_z,
    input  q32_t s_hint_up_x,
    input  q32_t s_hint_up_y,
    input  q32_t s_hint_up_z,
    output logic m_valid,
    input  logic m_ready,
    output q32_t m_side_x,
    output q32_t m_side_y,
    output q32_t m_side_z,
    output q32_t m_true_up_x,
    output q32_t m_true_up_y,
    output q32_t m_true_up_z,
    output q32_t m_back_x,
    output q32_t m_back_y,
    output q32_t m_back_z,
    output q32_t m_shift_x,
    output q32_t m_shift_y,
    output q32_t m_shift_z
);

    localparam int TL_STG = 8;

    typedef struct {
        logic valid;
        q32_t f [3];
        q32_t eye [3];
        w64_t prod [6];
        w64_t sr [3];
    } fr_t;

    typedef struct {
        logic valid;
        q32_t s [3];
        q32_t b [3];
        q32_t u [3];
        q32_t eye [3];
        w64_t prod [6];
        w64_t es [3];
        w64_t eb [3];
        w64_t eu [3];
        w64_t ur [3];
        w64_t ds;
        w64_t db;
        w64_t du;
        rnd_t urr [3];
        rnd_t ts;
        rnd_t tb;
        rnd_t tu;
        q32_t shx;
        q32_t shy;
        q32_t shz;
    } tl_t;

    // shift right by 30, round half away from zero
    function automatic rnd_t rnd30(w64_t v);
        w64_t t;
        t = v + (v[63] ? RND_NEG : RND_POS);
        return t[63:FRAC_W];
    endfunction

    function automatic q32_t neg_sat(rnd_t t);
        logic signed [34:0] n;
        n = -(35'(t));
        if (n > 35'(SAT_MAX)) begin
            return SAT_MAX;
        end else if (n < 35'(SAT_MIN)) begin
            return SAT_MIN;
        end
        return n[31:0];
    endfunction

    function automatic q32_t clamp_one(rnd_t t);
        if (t > rnd_t'(ONE_Q30)) begin
            return ONE_Q30;
        end else if (t < -rnd_t'(ONE_Q30)) begin
            return -ONE_Q30;
        end
        return t[31:0];
    endfunction

    logic             adv;
    w64_t             fwd [3];
    logic [5:0][31:0] n1_in_side, n1_side, n2_in_side, n2_side;
    logic             n1_valid, n2_valid;
    q32_t             n1_vec [3];
    q32_t             n2_vec [3];

    fr_t fr_reg  [1:2];
    fr_t fr_next [1:2];
    tl_t tl_reg  [1:TL_STG];
    tl_t tl_next [1:TL_STG];

    // advance everything unless a finished transaction is stuck at the output
    assign adv     = !tl_reg[TL_STG].valid || m_ready;
    assign s_ready = adv;

    assign fwd[0] = w64_t'(s_target_x) - w64_t'(s_eye_x);
    assign fwd[1] = w64_t'(s_target_y) - w64_t'(s_eye_y);
    assign fwd[2] = w64_t'(s_target_z) - w64_t'(s_eye_z);
    assign n1_in_side = {s_eye_x, s_eye_y, s_eye_z, s_hint_up_x, s_hint_up_y, s_hint_up_z};

    lkat_norm #(
        .SIDE_W (192)
    ) u_norm_fwd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_vec    (fwd),
        .in_side   (n1_in_side),
        .out_valid (n1_valid),
        .out_vec   (n1_vec),
        .out_side  (n1_side)
    );

    // f x up
    always_comb begin
        q32_t up [3];
        fr_next[1] = '{default: '0};
        fr_next[1].valid = n1_valid;
        for (int i = 0; i < 3; i++) begin
            fr_next[1].f[i]   = n1_vec[i];
            fr_next[1].eye[i] = n1_side[5-i];
            up[i]             = n1_side[2-i];
        end
        fr_next[1].prod[0] = n1_vec[1] * up[2];
        fr_next[1].prod[1] = n1_vec[2] * up[1];
        fr_next[1].prod[2] = n1_vec[2] * up[0];
        fr_next[1].prod[3] = n1_vec[0] * up[2];
        fr_next[1].prod[4] = n1_vec[0] * up[1];
        fr_next[1].prod[5] = n1_vec[1] * up[0];
    end

    always_comb begin
        fr_next[2] = fr_reg[1];
        for (int i = 0; i < 3; i++) begin
            fr_next[2].sr[i] = fr_reg[1].prod[2*i] - fr_reg[1].prod[2*i+1];
        end
    end

    assign n2_in_side = {fr_reg[2].f[0], fr_reg[2].f[1], fr_reg[2].f[2],
                         fr_reg[2].eye[0], fr_reg[2].eye[1], fr_reg[2].eye[2]};

    lkat_norm #(
        .SIDE_W (192)
    ) u_norm_side (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (fr_reg[2].valid),
        .in_vec    (fr_reg[2].sr),
        .in_side   (n2_in_side),
        .out_valid (n2_valid),
        .out_vec   (n2_vec),
        .out_side  (n2_side)
    );

    // s x f, and the side and back rows against the eye
    always_comb begin
        q32_t f [3];
        tl_next[1] = '{default: '0};
        tl_next[1].valid = n2_valid;
        for (int i = 0; i < 3; i++) begin
            f[i]              = n2_side[5-i];
            tl_next[1].eye[i] = n2_side[2-i];
            tl_next[1].s[i]   = n2_vec[i];
            tl_next[1].b[i]   = -f[i];
            tl_next[1].es[i]  = n2_vec[i] * tl_next[1].eye[i];
            tl_next[1].eb[i]  = tl_next[1].b[i] * tl_next[1].eye[i];
        end
        tl_next[1].prod[0] = n2_vec[1] * f[2];
        tl_next[1].prod[1] = n2_vec[2] * f[1];
        tl_next[1].prod[2] = n2_vec[2] * f[0];
        tl_next[1].prod[3] = n2_vec[0] * f[2];
        tl_next[1].prod[4] = n2_vec[0] * f[1];
        tl_next[1].prod[5] = n2_vec[1] * f[0];
    end

    always_comb begin
        tl_next[2] = tl_reg[1];
        for (int i = 0; i < 3; i++) begin
            tl_next[2].ur[i] = tl_reg[1].prod[2*i] - tl_reg[1].prod[2*i+1];
        end
        tl_next[2].ds = tl_reg[1].es[0] + tl_reg[1].es[1] + tl_reg[1].es[2];
        tl_next[2].db = tl_reg[1].eb[0] + tl_reg[1].eb[1] + tl_reg[1].eb[2];
    end

    always_comb begin
        tl_next[3] = tl_reg[2];
        for (int i = 0; i < 3; i++) begin
            tl_next[3].urr[i] = rnd30(tl_reg[2].ur[i]);
        end
        tl_next[3].ts = rnd30(tl_reg[2].ds);
        tl_next[3].tb = rnd30(tl_reg[2].db);
    end

    always_comb begin
        tl_next[4] = tl_reg[3];
        for (int i = 0; i < 3; i++) begin
            tl_next[4].u[i] = clamp_one(tl_reg[3].urr[i]);
        end
        tl_next[4].shx = neg_sat(tl_reg[3].ts);
        tl_next[4].shz = neg_sat(tl_reg[3].tb);
    end

    always_comb begin
        tl_next[5] = tl_reg[4];
        for (int i = 0; i < 3; i++) begin
            tl_next[5].eu[i] = tl_reg[4].u[i] * tl_reg[4].eye[i];
        end
    end

    always_comb begin
        tl_next[6] = tl_reg[5];
        tl_next[6].du = tl_reg[5].eu[0] + tl_reg[5].eu[1] + tl_reg[5].eu[2];
    end

    always_comb begin
        tl_next[7] = tl_reg[6];
        tl_next[7].tu = rnd30(tl_reg[6].du);
    end

    always_comb begin
        tl_next[8] = tl_reg[7];
        tl_next[8].shy = neg_sat(tl_reg[7].tu);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= 2; k++) begin
                fr_reg[k].valid <= 1'b0;
            end
            for (int k = 1; k <= TL_STG; k++) begin
                tl_reg[k].valid <= 1'b0;
            end
        end else if (adv) begin
            for (int k = 1; k <= 2; k++) begin
                fr_reg[k] <= fr_next[k];
            end
            for (int k = 1; k <= TL_STG; k++) begin
                tl_reg[k] <= tl_next[k];
            end
        end
    end

    assign m_valid     = tl_reg[TL_STG].valid;
    assign m_side_x    = tl_reg[TL_STG].s[0];
    assign m_side_y    = tl_reg[TL_STG].s[1];
    assign m_side_z    = tl_reg[TL_STG].s[2];
    assign m_true_up_x = tl_reg[TL_STG].u[0];
    assign m_true_up_y = tl_reg[TL_STG].u[1];
    assign m_true_up_z = tl_reg[TL_STG].u[2];
    assign m_back_x    = tl_reg[TL_STG].b[0];
    assign m_back_y    = tl_reg[TL_STG].b[1];
    assign m_back_z    = tl_reg[TL_STG].b[2];
    assign m_shift_x   = tl_reg[TL_STG].shx;
    assign m_shift_y   = tl_reg[TL_STG].shy;
    assign m_shift_z   = tl_reg[TL_STG].shz;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_side_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_side_x <= ONE_Q30 && m_side_x >= -ONE_Q30 &&
                     m_side_y <= ONE_Q30 && m_side_y >= -ONE_Q30 &&
                     m_side_z <= ONE_Q30 && m_side_z >= -ONE_Q30))
        else $error("side vector out of unit range");

    a_back_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_back_x == 0 && m_back_y == 0 && m_back_z == 0)
        |-> (m_side_x == 0 && m_side_y == 0 && m_side_z == 0 && m_shift_z == 0))
        else $error("zero forward vector gave nonzero side row");

    a_side_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_side_x == 0 && m_side_y == 0 && m_side_z == 0)
        |-> (m_true_up_x == 0 && m_true_up_y == 0 && m_true_up_z == 0 &&
             m_shift_x == 0 && m_shift_y == 0))
        else $error("zero side vector gave nonzero up row or shift");

endmodule

`default_nettype wire
